[rtl/core/zwcs_pkg.sv]
// shared types and constants of the zero-width character stripper
package zwcs_pkg;

    // byte codes of the stripped sequences
    localparam logic [7:0] BYTE_E2 = 8'he2;
    localparam logic [7:0] BYTE_80 = 8'h80;
    localparam logic [7:0] BYTE_8B = 8'h8b;
    localparam logic [7:0] BYTE_8C = 8'h8c;
    localparam logic [7:0] BYTE_81 = 8'h81;
    localparam logic [7:0] BYTE_A0 = 8'ha0;
    localparam logic [7:0] BYTE_EF = 8'hef;
    localparam logic [7:0] BYTE_BB = 8'hbb;
    localparam logic [7:0] BYTE_BF = 8'hbf;

    // most results one request can cause
    localparam int MAX_RES = 3;
    // result queue depth and pointer widths
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // held prefix
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_E2    = 3'd1,
        PH_E2_80 = 3'd2,
        PH_E2_81 = 3'd3,
        PH_EF    = 3'd4,
        PH_EF_BB = 3'd5
    } t_phase;

    // one result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       string_end;
    } t_res;

    typedef t_res [MAX_RES-1:0] t_res_vec;

    // bytes held for a given phase
    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_held;

endpackage

[rtl/core/zero_width_char_stripper_top.sv]
// top level of the zero-width character stripper
//
// usage
//   s_axis carries one utf-8 byte per request in tdata, tlast marks the last
//   byte of a string. m_axis carries the filtered text: tdata is the kept
//   byte, tlast marks the last result caused by one input request, tuser[0]
//   says tdata holds a byte (0 for a bare end marker), tuser[1] marks the
//   result that closes the output string.
//   u+200b, u+200c, u+2060 and u+feff are dropped; partial prefixes are held
//   until the next byte decides them, and a final byte flushes them.
// flow and throughput
//   a request accepted on s_axis sits in the input register, is decoded and
//   pushed into the result queue once the queue has room, and shows on m_axis
//   from then on. one request per cycle is taken as long as the result queue
//   holds at most one entry; results leave at one per cycle while m_axis_tready
//   is high, so the two or three results that one request can cause (flushed
//   prefixes) leave one after another on the output side.
// reset and stalls
//   synchronous active-low reset clears the held prefix, the input register
//   and the result queue. when m_axis stalls, the queue fills and s_axis_tready
//   drops once the queue cannot take a worst-case burst of three results.
module zero_width_char_stripper_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // is_final
    // output stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [0] byte_valid, [1] string_end
    output logic       m_axis_tlast    // run_last
);
    import zwcs_pkg::*;

    // input register
    logic            r_in_vld;
    logic [7:0]      r_in_byte;
    logic            r_in_fin;

    // held prefix state
    t_phase          r_phase;
    t_phase          n_phase;
    t_phase          w_judged;     // phase after this byte, before the final flush
    t_phase          w_flush_ph;   // prefix released by a mismatch
    logic            w_judge;      // current byte judged as a possible start
    logic            w_emit_cur;   // current byte is kept

    // decoded results of the request in the input register
    t_res_vec        w_res;
    logic [1:0]      w_nres;
    logic [1:0]      w_npush;
    logic            w_fire;

    // result queue
    t_res            r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_CW-1:0] r_cnt;
    logic            w_pop;

    function automatic t_held held_of(t_phase p);
        t_held h;
        h = '0;
        case (p)
            PH_E2:    begin h.cnt = 2'd1; h.b0 = BYTE_E2; end
            PH_E2_80: begin h.cnt = 2'd2; h.b0 = BYTE_E2; h.b1 = BYTE_80; end
            PH_E2_81: begin h.cnt = 2'd2; h.b0 = BYTE_E2; h.b1 = BYTE_81; end
            PH_EF:    begin h.cnt = 2'd1; h.b0 = BYTE_EF; end
            PH_EF_BB: begin h.cnt = 2'd2; h.b0 = BYTE_EF; h.b1 = BYTE_BB; end
            default:  h.cnt = 2'd0;
        endcase
        return h;
    endfunction

    // place a result at slot k of the list
    function automatic t_res_vec put_res(t_res_vec l, logic [1:0] k,
                                         logic [7:0] b, logic v);
        t_res_vec o;
        o = l;
        for (int j = 0; j < MAX_RES; j++) begin
            if (2'(j) == k) begin
                o[j].out_byte   = b;
                o[j].byte_valid = v;
            end
        end
        return o;
    endfunction

    // the queue has room for a worst-case burst
    assign w_fire        = r_in_vld && (r_cnt <= Q_CW'(Q_DEPTH - MAX_RES));
    assign s_axis_tready = !r_in_vld || w_fire;
    assign w_pop         = m_axis_tvalid && m_axis_tready;

    // next state
    always_comb begin
        w_judge    = 1'b0;
        w_flush_ph = PH_IDLE;
        w_judged   = PH_IDLE;
        case (r_phase)
            PH_E2: begin
                if (r_in_byte == BYTE_80) begin
                    w_judged = PH_E2_80;
                end else if (r_in_byte == BYTE_81) begin
                    w_judged = PH_E2_81;
                end else begin
                    w_judge    = 1'b1;
                    w_flush_ph = r_phase;
                end
            end
            PH_E2_80: begin
                if (r_in_byte == BYTE_8B || r_in_byte == BYTE_8C) begin
                    w_judged = PH_IDLE;
                end else begin
                    w_judge    = 1'b1;
                    w_flush_ph = r_phase;
                end
            end
            PH_E2_81: begin
                if (r_in_byte == BYTE_A0) begin
                    w_judged = PH_IDLE;
                end else begin
                    w_judge    = 1'b1;
                    w_flush_ph = r_phase;
                end
            end
            PH_EF: begin
                if (r_in_byte == BYTE_BB) begin
                    w_judged = PH_EF_BB;
                end else begin
                    w_judge    = 1'b1;
                    w_flush_ph = r_phase;
                end
            end
            PH_EF_BB: begin
                if (r_in_byte == BYTE_BF) begin
                    w_judged = PH_IDLE;
                end else begin
                    w_judge    = 1'b1;
                    w_flush_ph = r_phase;
                end
            end
            default: w_judge = 1'b1;
        endcase

        w_emit_cur = 1'b0;
        if (w_judge) begin
            if (r_in_byte == BYTE_E2) begin
                w_judged = PH_E2;
            end else if (r_in_byte == BYTE_EF) begin
                w_judged = PH_EF;
            end else begin
                w_judged   = PH_IDLE;
                w_emit_cur = 1'b1;
            end
        end

        n_phase = r_phase;
        if (w_fire) begin
            n_phase = r_in_fin ? PH_IDLE : w_judged;
        end
    end

    // results: released prefix, kept byte, final flush, bare end marker
    always_comb begin
        t_held      ha;
        t_held      hb;
        logic [1:0] k;
        ha    = held_of(w_flush_ph);
        hb    = held_of(r_in_fin ? w_judged : PH_IDLE);
        k     = 2'd0;
        w_res = '0;
        if (ha.cnt != 2'd0) begin
            w_res = put_res(w_res, k, ha.b0, 1'b1);
            k     = k + 2'd1;
        end
        if (ha.cnt == 2'd2) begin
            w_res = put_res(w_res, k, ha.b1, 1'b1);
            k     = k + 2'd1;
        end
        if (w_emit_cur) begin
            w_res = put_res(w_res, k, r_in_byte, 1'b1);
            k     = k + 2'd1;
        end
        if (hb.cnt != 2'd0) begin
            w_res = put_res(w_res, k, hb.b0, 1'b1);
            k     = k + 2'd1;
        end
        if (hb.cnt == 2'd2) begin
            w_res = put_res(w_res, k, hb.b1, 1'b1);
            k     = k + 2'd1;
        end
        if (r_in_fin && k == 2'd0) begin
            w_res = put_res(w_res, k, 8'h00, 1'b0);
            k     = k + 2'd1;
        end
        // mark the last result of this request
        for (int j = 0; j < MAX_RES; j++) begin
            if (2'(j) == k - 2'd1 && k != 2'd0) begin
                w_res[j].run_last   = 1'b1;
                w_res[j].string_end = r_in_fin;
            end
        end
        w_nres = k;
    end

    assign w_npush = w_fire ? w_nres : 2'd0;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_phase  <= PH_IDLE;
            r_wr     <= '0;
            r_rd     <= '0;
            r_cnt    <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            r_phase <= n_phase;
            r_wr    <= r_wr + Q_AW'(w_npush);
            if (w_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            r_cnt <= r_cnt + Q_CW'(w_npush) - Q_CW'(w_pop);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_fin  <= s_axis_tlast;
        end
        for (int i = 0; i < MAX_RES; i++) begin
            if (2'(i) < w_npush) begin
                r_q[r_wr + Q_AW'(i)] <= w_res[i];
            end
        end
    end

    assign m_axis_tvalid   = (r_cnt != '0);
    assign m_axis_tdata    = r_q[r_rd].out_byte;
    assign m_axis_tuser[0] = r_q[r_rd].byte_valid;
    assign m_axis_tuser[1] = r_q[r_rd].string_end;
    assign m_axis_tlast    = r_q[r_rd].run_last;

endmodule

[rtl/core/zwcs_checker.sv]
// port-level checks of the zero-width character stripper and their binding
module zwcs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // reset empties the output side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown right after reset");

    // string end only on the last result of a request
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("string end without run last");

    // a result without a byte is only the bare end marker
    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tuser[1] && m_axis_tlast && m_axis_tdata == 8'h00)
        else $error("empty result that is not an end marker");

endmodule

bind zero_width_char_stripper_top zwcs_checker u_zwcs_checker (.*);

[tb/sv/zero_width_char_stripper_top_tb.sv]
// testbench of the zero-width character stripper: scoreboard, stream drivers, checks
`timescale 1ns / 1ps

import zwcs_pkg::*;

// tracks the held prefix and the filtered bytes still owed by the block
class zwcs_scoreboard;
    t_phase held;
    t_res   owed_q[$];
    t_res   burst[$];
    int     errors;
    int     requests_seen;
    int     results_seen;
    int     strings_closed;
    int     chars_stripped;

    function new();
        held = PH_IDLE;
        errors = 0;
        requests_seen = 0;
        results_seen = 0;
        strings_closed = 0;
        chars_stripped = 0;
    endfunction

    function int pending();
        return owed_q.size();
    endfunction

    function void push_byte(logic [7:0] b, logic v);
        t_res r;
        r.out_byte   = b;
        r.byte_valid = v;
        r.run_last   = 1'b0;
        r.string_end = 1'b0;
        burst.push_back(r);
    endfunction

    // bytes given back when a prefix turns out not to be an invisible char
    function void release_prefix(t_phase p);
        case (p)
            PH_E2: push_byte(BYTE_E2, 1'b1);
            PH_E2_80: begin
                push_byte(BYTE_E2, 1'b1);
                push_byte(BYTE_80, 1'b1);
            end
            PH_E2_81: begin
                push_byte(BYTE_E2, 1'b1);
                push_byte(BYTE_81, 1'b1);
            end
            PH_EF: push_byte(BYTE_EF, 1'b1);
            PH_EF_BB: begin
                push_byte(BYTE_EF, 1'b1);
                push_byte(BYTE_BB, 1'b1);
            end
            default: ;
        endcase
    endfunction

    // a fresh byte either opens a prefix or passes straight through
    function t_phase open_prefix(logic [7:0] b);
        if (b == BYTE_E2) return PH_E2;
        if (b == BYTE_EF) return PH_EF;
        push_byte(b, 1'b1);
        return PH_IDLE;
    endfunction

    // accepted input request: work out the results it causes
    function void note_request(logic [7:0] b, logic fin);
        t_phase ph;
        ph = held;
        burst.delete();
        requests_seen++;
        case (ph)
            PH_E2: begin
                if (b == BYTE_80) ph = PH_E2_80;
                else if (b == BYTE_81) ph = PH_E2_81;
                else begin
                    release_prefix(ph);
                    ph = open_prefix(b);
                end
            end
            PH_E2_80: begin
                if (b == BYTE_8B || b == BYTE_8C) begin
                    ph = PH_IDLE;
                    chars_stripped++;
                end else begin
                    release_prefix(ph);
                    ph = open_prefix(b);
                end
            end
            PH_E2_81: begin
                if (b == BYTE_A0) begin
                    ph = PH_IDLE;
                    chars_stripped++;
                end else begin
                    release_prefix(ph);
                    ph = open_prefix(b);
                end
            end
            PH_EF: begin
                if (b == BYTE_BB) ph = PH_EF_BB;
                else begin
                    release_prefix(ph);
                    ph = open_prefix(b);
                end
            end
            PH_EF_BB: begin
                if (b == BYTE_BF) begin
                    ph = PH_IDLE;
                    chars_stripped++;
                end else begin
                    release_prefix(ph);
                    ph = open_prefix(b);
                end
            end
            default: ph = open_prefix(b);
        endcase
        if (fin) begin
            release_prefix(ph);
            ph = PH_IDLE;
            // nothing left to emit: a bare end marker closes the string
            if (burst.size() == 0) push_byte(8'h00, 1'b0);
        end
        held = ph;
        if (burst.size() > 0) begin
            burst[burst.size()-1].run_last   = 1'b1;
            burst[burst.size()-1].string_end = fin;
        end
        foreach (burst[i]) owed_q.push_back(burst[i]);
    endfunction

    // accepted output result: compare with the oldest owed one
    function void check_result(logic [7:0] data, logic [1:0] user, logic last);
        t_res want;
        results_seen++;
        if (user[1]) strings_closed++;
        if (owed_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("[%0t] unexpected result: byte %h valid %b last %b end %b",
                         $time, data, user[0], last, user[1]);
            return;
        end
        want = owed_q.pop_front();
        if (want.out_byte !== data || want.byte_valid !== user[0] ||
            want.run_last !== last || want.string_end !== user[1]) begin
            errors++;
            if (errors <= 10) begin
                $display("[%0t] result %0d mismatch: expected byte %h valid %b last %b end %b",
                         $time, results_seen, want.out_byte, want.byte_valid, want.run_last,
                         want.string_end);
                $display("    got byte %h valid %b last %b end %b",
                         data, user[0], last, user[1]);
            end
        end
    endfunction
endclass

module zero_width_char_stripper_top_tb;

    localparam int QUIET_LIMIT = 2000;   // cycles without any handshake
    localparam int HOLD_CYCLES = 80;     // long receiver hold-off

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic       s_axis_tlast = 1'b0;    // is_final
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic [1:0] m_axis_tuser;           // [0] byte_valid, [1] string_end
    logic       m_axis_tlast;           // run_last

    zwcs_scoreboard sb = new();

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_reqs = 0;
    int hold_done = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    logic [7:0] text_q[$];

    zero_width_char_stripper_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_reqs != hold_done) begin
            hold_done++;
            hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // monitor both handshakes and watch for a hung block
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("no handshake for %0d cycles, %0d results still owed",
                         quiet_cycles, sb.pending());
                $display("zero_width_char_stripper_top test failed");
                $finish;
            end
        end
    end

    // offer one byte, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // first len bytes of one of the four stripped characters
    function automatic void push_seq(int k, int len);
        logic [7:0] s [3];
        case (k)
            0:       s = '{BYTE_E2, BYTE_80, BYTE_8B};
            1:       s = '{BYTE_E2, BYTE_80, BYTE_8C};
            2:       s = '{BYTE_E2, BYTE_81, BYTE_A0};
            default: s = '{BYTE_EF, BYTE_BB, BYTE_BF};
        endcase
        for (int i = 0; i < len; i++) text_q.push_back(s[i]);
    endfunction

    // random strings built from invisible chars, broken prefixes and plain bytes
    task automatic run_random(input int n_items);
        int sent;
        int pieces;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            text_q.delete();
            pieces = $urandom_range(10, 1);
            repeat (pieces) begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    push_seq($urandom_range(3), 3);
                end else if (pick < 55) begin
                    push_seq($urandom_range(3), $urandom_range(2, 1));
                    if ($urandom_range(1)) text_q.push_back(8'($urandom_range(255)));
                end else if (pick < 65) begin
                    case ($urandom_range(4))
                        0:       text_q.push_back(BYTE_E2);
                        1:       text_q.push_back(BYTE_EF);
                        2:       text_q.push_back(BYTE_80);
                        3:       text_q.push_back(BYTE_81);
                        default: text_q.push_back(BYTE_BB);
                    endcase
                end else begin
                    text_q.push_back(8'($urandom_range(255)));
                end
            end
            foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
            sent += text_q.size();
        end
    endtask

    int tx_pct_tab [4] = '{0, 71, 0, 18};
    int rx_pct_tab [4] = '{0, 0, 71, 18};

    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);

        // directed: byte extremes, each stripped char, near misses, flushes
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(BYTE_E2, 1'b0);
        send_byte(BYTE_80, 1'b0);
        send_byte(BYTE_8B, 1'b0);
        send_byte(BYTE_E2, 1'b0);
        send_byte(BYTE_80, 1'b0);
        send_byte(BYTE_8C, 1'b0);
        send_byte(BYTE_E2, 1'b0);
        send_byte(BYTE_81, 1'b0);
        send_byte(BYTE_A0, 1'b0);
        send_byte(BYTE_EF, 1'b0);
        send_byte(BYTE_BB, 1'b0);
        send_byte(BYTE_BF, 1'b1);   // string ends on a dropped char: bare end marker
        send_byte(BYTE_E2, 1'b0);
        send_byte(BYTE_80, 1'b0);
        send_byte(8'h8d, 1'b0);     // zero-width joiner is kept
        send_byte(BYTE_E2, 1'b0);
        send_byte(BYTE_81, 1'b0);
        send_byte(BYTE_EF, 1'b0);   // held second byte given back, new prefix opened
        send_byte(BYTE_BB, 1'b0);
        send_byte(BYTE_E2, 1'b0);
        send_byte(BYTE_E2, 1'b0);
        send_byte(BYTE_80, 1'b1);   // final byte flushes the held prefix

        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct  = tx_pct_tab[ph];
            rx_stall_pct = rx_pct_tab[ph];
            // receiver holds off while the sender keeps offering
            if (ph == 0 || ph == 3) hold_reqs++;
            run_random(60);
        end
        s_axis_tvalid <= 1'b0;
        rx_stall_pct = 0;
        // let the monitor note the last request before draining
        @(posedge i_clk);

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("sent %0d bytes in all idle mixes, %0d invisible chars removed",
                 sb.requests_seen, sb.chars_stripped);
        $display("checked %0d results over %0d strings, %0d mismatches",
                 sb.results_seen, sb.strings_closed, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("zero_width_char_stripper_top test passed");
        else
            $display("zero_width_char_stripper_top test failed");
        $finish;
    end

endmodule
